### design/crfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfe_pkg
// Shared sizes, command codes, RAM write word and clamp helper for the
// clipped rectangle fill engine.
// ----------------------------------------------------------------------------
package crfe_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CRD_W      = 7;
    localparam int PROD_W     = 2 * CRD_W;
    localparam int PIX_W      = 32;
    localparam int POS_W      = 16;
    localparam int PROBE_W    = 6;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    localparam logic [CRD_W-1:0] WIDTH_LIMIT  = CRD_W'(MAX_WIDTH);
    localparam logic [CRD_W-1:0] HEIGHT_LIMIT = CRD_W'(MAX_HEIGHT);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } crfe_wr_t;

    function automatic logic [CRD_W-1:0] clamp_pos(
        input logic signed [POS_W-1:0] v,
        input logic        [CRD_W-1:0] hi
    );
        logic [CRD_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({{(POS_W-CRD_W){1'b0}}, hi}))
            r = hi;
        else
            r = v[CRD_W-1:0];
        return r;
    endfunction

endpackage

### design/crfe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfe_if
// Valid/ready channels of the fill engine: command, response, config.
// ----------------------------------------------------------------------------
interface crfe_cmd_if;
    import crfe_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [POS_W-1:0]   left_x;
    logic signed [POS_W-1:0]   top_y;
    logic signed [POS_W-1:0]   right_x;
    logic signed [POS_W-1:0]   bottom_y;
    logic [PIX_W-1:0]          fill_color;
    logic [PROBE_W-1:0]        probe_x;
    logic [PROBE_W-1:0]        probe_y;

    modport source (output valid, kind, left_x, top_y, right_x, bottom_y,
                    fill_color, probe_x, probe_y, input ready);
    modport sink   (input valid, kind, left_x, top_y, right_x, bottom_y,
                    fill_color, probe_x, probe_y, output ready);
endinterface

interface crfe_rsp_if;
    import crfe_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             in_range;

    modport source (output valid, pixel_value, in_range, input ready);
    modport sink   (input valid, pixel_value, in_range, output ready);
endinterface

interface crfe_cfg_if;
    import crfe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CRD_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/crfe_pixel_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfe_pixel_ram
// Pixel store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module crfe_pixel_ram (
    input  logic                     clk,
    input  crfe_pkg::crfe_wr_t       wr,
    input  logic [crfe_pkg::ADDR_W-1:0] raddr,
    output logic [crfe_pkg::PIX_W-1:0]  rdata
);
    import crfe_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/clipped_rectangle_fill_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_rectangle_fill_engine_core
// Framebuffer clear / clipped rectangle fill / pixel read-back engine.
//
// cmd: one word per command (clear, fill rectangle, read pixel). cmd.ready
//   is high only while the sequencer is idle.
// cfg: screen_width (index 0) and screen_height (index 1); always ready,
//   write only while no command is in flight.
// rsp: one word per read command; none for clear or fill.
// Fill clamps the corners to the screen and clear covers the whole screen;
//   both then walk the rectangle row by row, one pixel write per cycle;
//   an empty rectangle or screen, and kind 3, write nothing.
// A read passes through the address register, the RAM read register and
//   the response register. The response is held while rsp.ready is low;
//   a following command may be taken meanwhile, and a second read waits
//   in its last state until the held word is taken.
// Reset sets width and height to 64 and empties the response register;
//   pixel contents are undefined until a clear writes them.
// ----------------------------------------------------------------------------
module clipped_rectangle_fill_engine_core (
    input  logic       clk,
    input  logic       rst_n,
    crfe_cfg_if.sink   cfg,
    crfe_cmd_if.sink   cmd,
    crfe_rsp_if.source rsp
);
    import crfe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_FILL,
        ST_RD_ISSUE,
        ST_RD_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CRD_W-1:0]  width_reg, width_next;
    logic [CRD_W-1:0]  height_reg, height_next;
    logic [CRD_W-1:0]  x0_reg, x0_next;
    logic [CRD_W-1:0]  x1_reg, x1_next;
    logic [CRD_W-1:0]  y1_reg, y1_next;
    logic [CRD_W-1:0]  x_reg, x_next;
    logic [CRD_W-1:0]  y_reg, y_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] raddr_reg, raddr_next;
    logic [PIX_W-1:0]  color_reg, color_next;
    logic              ok_reg, ok_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [PIX_W-1:0]  rsp_value_reg, rsp_value_next;
    logic              rsp_ok_reg, rsp_ok_next;

    logic [CRD_W-1:0]  w_eff, h_eff;
    logic [CRD_W-1:0]  cx0, cx1, cy0, cy1;
    logic [CRD_W-1:0]  x_inc, y_inc;
    logic [PROD_W-1:0] read_prod, row_prod;
    logic [PIX_W-1:0]  rdata;
    crfe_wr_t          wr;

    assign w_eff = (width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : width_reg;
    assign h_eff = (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;

    assign cx0 = clamp_pos(cmd.left_x, w_eff);
    assign cx1 = clamp_pos(cmd.right_x, w_eff);
    assign cy0 = clamp_pos(cmd.top_y, h_eff);
    assign cy1 = clamp_pos(cmd.bottom_y, h_eff);

    assign x_inc     = x_reg + CRD_W'(1);
    assign y_inc     = y_reg + CRD_W'(1);
    assign read_prod = PROD_W'(w_eff) * PROD_W'(cmd.probe_y);
    assign row_prod  = PROD_W'(w_eff) * PROD_W'(y_reg);

    assign cfg.ready       = 1'b1;
    assign cmd.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.pixel_value = rsp_value_reg;
    assign rsp.in_range    = rsp_ok_reg;

    assign wr.we   = (state_reg == ST_FILL);
    assign wr.addr = base_reg + ADDR_W'(x_reg);
    assign wr.data = color_reg;

    crfe_pixel_ram u_ram (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        base_next      = base_reg;
        raddr_next     = raddr_reg;
        color_next     = color_reg;
        ok_next        = ok_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_value_next = rsp_value_reg;
        rsp_ok_next    = rsp_ok_reg;

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_WIDTH:  width_next  = cfg.data;
                REG_HEIGHT: height_next = cfg.data;
                default:    ;
            endcase
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    color_next = cmd.fill_color;
                    case (cmd.kind)
                        KIND_CLEAR:
                        begin
                            x0_next = '0;
                            x_next  = '0;
                            y_next  = '0;
                            x1_next = w_eff;
                            y1_next = h_eff;
                            if (w_eff != '0 && h_eff != '0)
                                state_next = ST_ROW;
                        end
                        KIND_FILL:
                        begin
                            x0_next = cx0;
                            x_next  = cx0;
                            y_next  = cy0;
                            x1_next = cx1;
                            y1_next = cy1;
                            if (cx0 < cx1 && cy0 < cy1)
                                state_next = ST_ROW;
                        end
                        KIND_READ:
                        begin
                            raddr_next = ADDR_W'(cmd.probe_x) + read_prod[ADDR_W-1:0];
                            ok_next    = ({1'b0, cmd.probe_x} < w_eff) &&
                                         ({1'b0, cmd.probe_y} < h_eff);
                            state_next = ST_RD_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROW:
            begin
                base_next  = row_prod[ADDR_W-1:0];
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (x_inc == x1_reg)
                begin
                    x_next    = x0_reg;
                    y_next    = y_inc;
                    base_next = base_reg + ADDR_W'(w_eff);
                    if (y_inc == y1_reg)
                        state_next = ST_IDLE;
                end
                else
                begin
                    x_next = x_inc;
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_DONE;
            end
            ST_RD_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = ok_reg;
                    rsp_value_next = ok_reg ? rdata : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= WIDTH_LIMIT;
            height_reg    <= HEIGHT_LIMIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg        <= x0_next;
        x1_reg        <= x1_next;
        y1_reg        <= y1_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        base_reg      <= base_next;
        raddr_reg     <= raddr_next;
        color_reg     <= color_next;
        ok_reg        <= ok_next;
        rsp_value_reg <= rsp_value_next;
        rsp_ok_reg    <= rsp_ok_next;
    end

endmodule
